// ===== rtl/core/task_watchdog_table_top_macros.svh =====
// Assertion macros for the task watchdog table checker.
// No dependencies; included by the checker file.
`ifndef TASK_WATCHDOG_TABLE_TOP_MACROS_SVH
`define TASK_WATCHDOG_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TWT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/twt_pkg.sv =====
// Shared types and codes for the task watchdog table.
// No dependencies; used by every module of the block.
`default_nettype none

package twt_pkg;

    localparam int NUM_WATCHDOGS_DEF = 16;

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_KICK     = 2'd1;
    localparam logic [1:0] ACT_CHECK    = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_FULL         = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [2:0] ST_TIMED_OUT    = 3'd3;
    localparam logic [2:0] ST_NONE_EXPIRED = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  task_id;
        logic [31:0] timeout_ms;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] reported_task;
        logic       last;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [7:0]  task_id;
        logic [31:0] kick_time;
        logic [31:0] timeout;
    } t_entry;

    typedef struct packed {
        logic push;
        logic rotate;
    } t_shift_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/task_watchdog_table_top.sv =====
// Task watchdog table: a ring of NUM_WATCHDOGS entry cells plus a sequencer.
// Results appear one per cycle on o_res with the strobe o_res_valid and are not
// held: the receiver cannot stall and must take each one in the cycle it shows.
// The result of a register request follows in the next cycle; start may be
// high again right away. A kick or check request keeps busy high while the
// ring rotates once so every entry passes the head cell, newest first, and a
// final busy step closes the scan; the last result shows in the same cycle
// that busy drops. Each check hit is held until the next hit is found and
// shows in the cycle after that, so the final hit can carry last. Valid marks
// clear at reset.
// Depends on twt_pkg, twt_cell, twt_ctrl.
`default_nettype none

module task_watchdog_table_top #(
    parameter int NUM_WATCHDOGS = twt_pkg::NUM_WATCHDOGS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire twt_pkg::t_in  i_req,
    output logic               busy,
    output logic               o_res_valid,
    output twt_pkg::t_out      o_res
);
    import twt_pkg::*;

    t_entry     cell_q [NUM_WATCHDOGS];
    t_shift_ctl ctl;
    t_entry     push_entry;
    t_entry     head_wb;

    twt_ctrl #(
        .NUM_WATCHDOGS(NUM_WATCHDOGS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_head      (cell_q[0]),
        .i_full      (cell_q[NUM_WATCHDOGS-1].valid),
        .o_busy      (busy),
        .o_ctl       (ctl),
        .o_push_entry(push_entry),
        .o_head_wb   (head_wb),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    for (genvar gi = 0; gi < NUM_WATCHDOGS; gi++) begin : g_cell
        t_entry push_src;
        t_entry rot_src;

        if (gi == 0) begin : g_first
            assign push_src = push_entry;
        end else begin : g_inner_push
            assign push_src = cell_q[gi-1];
        end

        // tail closes the ring with the head entry, possibly refreshed
        if (gi == NUM_WATCHDOGS - 1) begin : g_tail
            assign rot_src = head_wb;
        end else begin : g_inner_rot
            assign rot_src = cell_q[gi+1];
        end

        twt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_push_src(push_src),
            .i_rot_src (rot_src),
            .o_entry   (cell_q[gi])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/core/twt_cell.sv =====
// One watchdog entry of the cell ring, shifting toward the tail on a push
// and toward the head on a rotate. Depends on twt_pkg.
`default_nettype none

module twt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire twt_pkg::t_shift_ctl i_ctl,
    input  wire twt_pkg::t_entry     i_push_src,
    input  wire twt_pkg::t_entry     i_rot_src,
    output twt_pkg::t_entry          o_entry
);
    import twt_pkg::*;

    logic        r_valid;
    logic [7:0]  r_task;
    logic [31:0] r_kick;
    logic [31:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.push) begin
            r_valid <= i_push_src.valid;
        end else if (i_ctl.rotate) begin
            r_valid <= i_rot_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_task    <= i_push_src.task_id;
            r_kick    <= i_push_src.kick_time;
            r_timeout <= i_push_src.timeout;
        end else if (i_ctl.rotate) begin
            r_task    <= i_rot_src.task_id;
            r_kick    <= i_rot_src.kick_time;
            r_timeout <= i_rot_src.timeout;
        end
    end

    assign o_entry = '{valid: r_valid, task_id: r_task, kick_time: r_kick,
                       timeout: r_timeout};

endmodule

`default_nettype wire

// ===== rtl/core/twt_ctrl.sv =====
// Request sequencer: decodes requests, drives the cell ring and evaluates
// the head cell during a scan. Depends on twt_pkg.
`default_nettype none

module twt_ctrl #(
    parameter int NUM_WATCHDOGS = twt_pkg::NUM_WATCHDOGS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire twt_pkg::t_in        i_req,
    input  wire twt_pkg::t_entry     i_head,
    input  wire logic                i_full,
    output logic                     o_busy,
    output twt_pkg::t_shift_ctl      o_ctl,
    output twt_pkg::t_entry          o_push_entry,
    output twt_pkg::t_entry          o_head_wb,
    output logic                     o_res_valid,
    output twt_pkg::t_out            o_res
);
    import twt_pkg::*;

    localparam int CW = $clog2(NUM_WATCHDOGS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_KICK  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_found, n_found;
    logic          r_held, n_held;
    logic [7:0]    r_held_task, n_held_task;
    logic [7:0]    r_task;
    logic [31:0]   r_now;
    logic          r_out_valid, n_out_valid;
    t_out          r_out, n_out;

    logic          accept;
    logic          scan_end;
    logic [31:0]   elapsed;
    logic          expired;
    logic          match;

    assign accept   = i_start && (r_state == S_IDLE);
    assign scan_end = (r_cnt == CW'(NUM_WATCHDOGS));
    assign elapsed  = r_now - i_head.kick_time;
    assign expired  = i_head.valid && (elapsed > i_head.timeout);
    assign match    = i_head.valid && (i_head.task_id == r_task);

    assign o_push_entry = '{valid: 1'b1, task_id: i_req.task_id,
                            kick_time: i_req.now_ms, timeout: i_req.timeout_ms};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_held      = r_held;
        n_held_task = r_held_task;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_ctl       = '{push: 1'b0, rotate: 1'b0};
        o_head_wb   = i_head;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req.action)
                        ACT_REGISTER: begin
                            n_out_valid = 1'b1;
                            n_out = '{status: i_full ? ST_FULL : ST_OK,
                                      reported_task: i_req.task_id, last: 1'b1};
                            o_ctl.push = !i_full;
                        end
                        ACT_KICK: begin
                            n_state = S_KICK;
                            n_cnt   = '0;
                            n_found = 1'b0;
                        end
                        ACT_CHECK: begin
                            n_state = S_CHECK;
                            n_cnt   = '0;
                            n_held  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_KICK: begin
                if (scan_end) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: r_found ? ST_OK : ST_NOT_FOUND,
                              reported_task: r_task, last: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    // newest entry leaves the head first; refresh only the first hit
                    o_ctl.rotate = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    if (match && !r_found) begin
                        o_head_wb.kick_time = r_now;
                        n_found = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (scan_end) begin
                    n_out_valid = 1'b1;
                    if (r_held) begin
                        n_out = '{status: ST_TIMED_OUT, reported_task: r_held_task,
                                  last: 1'b1};
                    end else begin
                        n_out = '{status: ST_NONE_EXPIRED, reported_task: 8'd0,
                                  last: 1'b1};
                    end
                    n_state = S_IDLE;
                end else begin
                    o_ctl.rotate = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    // hold each hit until the next is found so the final one can carry last
                    if (expired) begin
                        if (r_held) begin
                            n_out_valid = 1'b1;
                            n_out = '{status: ST_TIMED_OUT, reported_task: r_held_task,
                                      last: 1'b0};
                        end
                        n_held      = 1'b1;
                        n_held_task = i_head.task_id;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_task <= n_held_task;
        r_out       <= n_out;
        if (accept) begin
            r_task <= i_req.task_id;
            r_now  <= i_req.now_ms;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/twt_checker.sv =====
// Port-level checks for the task watchdog table, bound to the top level.
// Depends on twt_pkg and task_watchdog_table_top_macros.svh.
`default_nettype none

`include "task_watchdog_table_top_macros.svh"

module twt_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire twt_pkg::t_in  i_req,
    input wire logic          busy,
    input wire logic          o_res_valid,
    input wire twt_pkg::t_out o_res
);
    import twt_pkg::*;

    logic req_reg;
    logic req_scan;
    logic res_final;
    logic res_mid;
    logic res_none;
    logic none_ok;

    assign req_reg   = start && !busy && (i_req.action == ACT_REGISTER);
    assign req_scan  = start && !busy &&
                       (i_req.action == ACT_KICK || i_req.action == ACT_CHECK);
    assign res_final = o_res_valid && o_res.last;
    assign res_mid   = o_res_valid && !o_res.last;
    assign res_none  = o_res_valid && (o_res.status == ST_NONE_EXPIRED);
    assign none_ok   = (o_res.reported_task == 8'd0) && o_res.last;

    `TWT_ASSERT_NEXT(a_reg_answers, i_clk, i_rst_n, req_reg, res_final, "register unanswered")
    `TWT_ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n, req_scan, busy, "scan did not raise busy")
    `TWT_ASSERT_NOW(a_scan_ends, i_clk, i_rst_n, $fell(busy), res_final, "scan without last")
    `TWT_ASSERT_NOW(a_mid_in_scan, i_clk, i_rst_n, res_mid, busy, "mid result outside scan")
    `TWT_ASSERT_NOW(a_none_form, i_clk, i_rst_n, res_none, none_ok, "bad none-expired result")

endmodule

bind task_watchdog_table_top twt_checker u_twt_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for task_watchdog_table_top: drives register, kick and
// check requests and compares every result against a built-in table tracker.
// Depends on twt_pkg and the task_watchdog_table_top RTL.

module tb;

    import twt_pkg::*;

    localparam int          DEPTH       = NUM_WATCHDOGS_DEF;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          PRINT_CAP   = 40;
    localparam int          RAND_ITEMS  = 200;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    // Mirrors the watchdog table and holds the reports still owed by the block.
    class watchdog_tracker;
        logic [7:0]  task_of [DEPTH];
        logic [31:0] kick_at [DEPTH];
        logic [31:0] limit_of[DEPTH];
        int          used;
        t_out        expected_reports[$];
        int          mismatches;

        function new();
            used = 0;
            mismatches = 0;
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function t_out mk(logic [2:0] st, logic [7:0] tid, logic lst);
            t_out o;
            o.status = st;
            o.reported_task = tid;
            o.last = lst;
            return o;
        endfunction

        // Work out the reports that one accepted request causes.
        function void note_request(t_in r);
            t_out        hits[$];
            logic [31:0] elapsed;
            bit          found;
            found = 0;
            case (r.action)
                ACT_REGISTER: begin
                    if (used >= DEPTH) begin
                        expected_reports.push_back(mk(ST_FULL, r.task_id, 1'b1));
                    end else begin
                        task_of[used]  = r.task_id;
                        kick_at[used]  = r.now_ms;
                        limit_of[used] = r.timeout_ms;
                        used++;
                        expected_reports.push_back(mk(ST_OK, r.task_id, 1'b1));
                    end
                end
                ACT_KICK: begin
                    for (int i = used - 1; i >= 0 && !found; i--) begin
                        if (task_of[i] == r.task_id) begin
                            kick_at[i] = r.now_ms;
                            found = 1;
                        end
                    end
                    expected_reports.push_back(
                        mk(found ? ST_OK : ST_NOT_FOUND, r.task_id, 1'b1));
                end
                ACT_CHECK: begin
                    for (int i = used - 1; i >= 0; i--) begin
                        elapsed = r.now_ms - kick_at[i];
                        if (elapsed > limit_of[i])
                            hits.push_back(mk(ST_TIMED_OUT, task_of[i], 1'b0));
                    end
                    if (hits.size() == 0) begin
                        expected_reports.push_back(mk(ST_NONE_EXPIRED, 8'd0, 1'b1));
                    end else begin
                        foreach (hits[k]) begin
                            if (k == hits.size() - 1)
                                hits[k].last = 1'b1;
                            expected_reports.push_back(hits[k]);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task check_result(t_out got);
            t_out want;
            if (expected_reports.size() == 0) begin
                report($sformatf("unexpected result status=%0d task=%0d last=%0d",
                                 got.status, got.reported_task, got.last));
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status got %0d want %0d",
                                     got.status, want.status));
                if (got.reported_task !== want.reported_task)
                    report($sformatf("reported_task got %0d want %0d",
                                     got.reported_task, want.reported_task));
                if (got.last !== want.last)
                    report($sformatf("last got %0d want %0d", got.last, want.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_req;
    logic busy;
    logic o_res_valid;
    t_out o_res;

    watchdog_tracker tracker = new();
    int              cycle_count = 0;
    bit              no_gaps = 0;
    logic [31:0]     now_base;
    logic [7:0]      known_ids[$];

    task_watchdog_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Results cannot be held off: take each one at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            tracker.check_result(o_res);
    end

    function t_in noise_req();
        t_in r;
        r.action = 2'($urandom);
        r.task_id = 8'($urandom);
        r.timeout_ms = $urandom;
        r.now_ms = $urandom;
        return r;
    endfunction

    // Hold start and the request until accepted, then idle for a random gap.
    task send(t_in r);
        int gap;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        tracker.note_request(r);
        if (r.action == ACT_REGISTER)
            known_ids.push_back(r.task_id);
        if (no_gaps)
            gap = 0;
        else if ($urandom_range(99) < 50)
            gap = 0;
        else if ($urandom_range(99) < 85)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(40, 10);
        if (gap > 0) begin
            start <= 1'b0;
            i_req <= noise_req();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_fields(logic [1:0] act, logic [7:0] tid, logic [31:0] tmo, logic [31:0] now);
        t_in r;
        r.action = act;
        r.task_id = tid;
        r.timeout_ms = tmo;
        r.now_ms = now;
        send(r);
    endtask

    initial begin
        t_in r;
        int  pick;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, unused code, duplicates, boundary and wrap.
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'h0);
        send_fields(ACT_KICK,     8'hA5, 32'h0,         32'h0);
        send_fields(ACT_UNUSED,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(ACT_REGISTER, 8'h00, 32'h0,         32'h0);
        send_fields(ACT_REGISTER, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(ACT_REGISTER, 8'h3C, 32'd10,        32'd100);
        send_fields(ACT_REGISTER, 8'h00, 32'd5,         32'd100);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'd100);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'd106);
        send_fields(ACT_KICK,     8'h00, 32'h0,         32'd106);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'd106);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'd110);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'd111);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'hFFFF_FFFE);
        send_fields(ACT_KICK,     8'h77, 32'h0,         32'd50);
        send_fields(ACT_KICK,     8'hFF, 32'h0,         32'd0);
        send_fields(ACT_CHECK,    8'h00, 32'h0,         32'd0);

        // Random: advancing wrapping time, ids mostly from the registered pool.
        now_base = 32'hFFFF_F000;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 25 == 0)
                no_gaps = ($urandom_range(3) == 0);
            pick = $urandom_range(99);
            if (pick < 12)
                r.action = ACT_REGISTER;
            else if (pick < 52)
                r.action = ACT_KICK;
            else if (pick < 92)
                r.action = ACT_CHECK;
            else
                r.action = ACT_UNUSED;
            if (known_ids.size() > 0 && $urandom_range(99) < 80)
                r.task_id = known_ids[$urandom_range(known_ids.size() - 1)];
            else
                r.task_id = 8'($urandom);
            pick = $urandom_range(99);
            if (pick < 50)
                r.timeout_ms = $urandom_range(200);
            else if (pick < 75)
                r.timeout_ms = $urandom;
            else if (pick < 87)
                r.timeout_ms = 32'h0;
            else
                r.timeout_ms = 32'hFFFF_FFFF;
            if ($urandom_range(99) < 5)
                now_base = $urandom;
            else
                now_base = now_base + $urandom_range(40);
            r.now_ms = now_base;
            send(r);
        end

        // Fill the table, then overflow it once and scan it.
        while (tracker.used < DEPTH)
            send_fields(ACT_REGISTER, 8'($urandom), $urandom_range(100), now_base);
        send_fields(ACT_REGISTER, 8'h5A, 32'd1, now_base);
        send_fields(ACT_CHECK, 8'h00, 32'h0, now_base + 32'd50);

        start <= 1'b0;
        while (tracker.expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/twt_pkg.sv
rtl/core/twt_cell.sv
rtl/core/twt_ctrl.sv
rtl/core/task_watchdog_table_top.sv
rtl/core/twt_checker.sv
tb/tb.sv
